### hdl/cta_pkg.sv
`default_nettype none

package cta_pkg;

   localparam int TABLE_SLOTS_DEFAULT = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [31:0] TIMEOUT_RESET = 32'd5000;
   localparam logic [9:0]  START_BALANCE = 10'd1000;

   localparam logic [2:0] CMD_CONNECT    = 3'd0;
   localparam logic [2:0] CMD_DISCONNECT = 3'd1;
   localparam logic [2:0] CMD_TOUCH      = 3'd2;
   localparam logic [2:0] CMD_LOOKUP     = 3'd3;
   localparam logic [2:0] CMD_SWEEP      = 3'd4;
   localparam logic [2:0] CMD_CLEAR      = 3'd5;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   typedef enum logic [2:0] {
      OP_CONNECT,
      OP_DISCONNECT,
      OP_TOUCH,
      OP_LOOKUP,
      OP_SWEEP,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [47:0] client_addr;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  balance;
      logic [31:0] seen_time;
      logic [3:0]  live_count;
      logic [3:0]  evicted_count;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [47:0] addr;
      logic [31:0] now;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

`default_nettype wire

### hdl/cta_front.sv
`default_nettype none

module cta_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire cta_pkg::req_type  req_data,
   input  wire cta_pkg::q_stat_type q_stat,
   output logic                   q_push,
   output cta_pkg::job_type       q_job
);

   logic             hold_vld_ff, hold_vld_in;
   cta_pkg::job_type hold_job_ff, hold_job_in;
   cta_pkg::op_type  op_dec;

   always_comb begin
      unique case (req_data.cmd)
         cta_pkg::CMD_CONNECT:    op_dec = cta_pkg::OP_CONNECT;
         cta_pkg::CMD_DISCONNECT: op_dec = cta_pkg::OP_DISCONNECT;
         cta_pkg::CMD_TOUCH:      op_dec = cta_pkg::OP_TOUCH;
         cta_pkg::CMD_LOOKUP:     op_dec = cta_pkg::OP_LOOKUP;
         cta_pkg::CMD_SWEEP:      op_dec = cta_pkg::OP_SWEEP;
         cta_pkg::CMD_CLEAR:      op_dec = cta_pkg::OP_CLEAR;
         default:                 op_dec = cta_pkg::OP_NOP;
      endcase
   end

   assign busy   = hold_vld_ff;
   assign q_push = hold_vld_ff && !q_stat.full;
   assign q_job  = hold_job_ff;

   always_comb begin
      hold_vld_in = hold_vld_ff;
      hold_job_in = hold_job_ff;
      if (q_push) begin
         hold_vld_in = 1'b0;
      end
      if (start && !hold_vld_ff) begin
         hold_vld_in      = 1'b1;
         hold_job_in.op   = op_dec;
         hold_job_in.addr = req_data.client_addr;
         hold_job_in.now  = req_data.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
      end
      hold_job_ff <= hold_job_in;
   end

endmodule

`default_nettype wire

### hdl/cta_queue.sv
`default_nettype none

module cta_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cta_pkg::job_type  push_job,
   input  wire logic              pop,
   output cta_pkg::job_type       head_job,
   output cta_pkg::q_stat_type    stat
);

   localparam int DEPTH = cta_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cta_pkg::job_type   slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### hdl/cta_engine.sv
`default_nettype none

module cta_engine #(
   parameter int TABLE_SLOTS = cta_pkg::TABLE_SLOTS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [31:0]       csr_wdata,
   input  wire cta_pkg::job_type  head_job,
   input  wire cta_pkg::q_stat_type q_stat,
   output logic                   q_pop,
   output logic                   rsp_valid,
   output cta_pkg::rsp_type       rsp_data
);

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   // table storage
   logic [47:0] addr_mem [TABLE_SLOTS];
   logic [31:0] seen_mem [TABLE_SLOTS];
   logic [47:0] rd_addr_ff;
   logic [31:0] rd_seen_ff;

   state_type          state_ff, state_in;
   cta_pkg::job_type   job_ff, job_in;
   logic [TABLE_SLOTS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]   live_ff, live_in;
   logic [CNT_W-1:0]   evict_ff, evict_in;
   logic [CNT_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               chk_vld_ff, chk_vld_in;
   logic               match_ff, match_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic [31:0]        match_seen_ff, match_seen_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [31:0]        timeout_ff, timeout_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cta_pkg::rsp_type   rsp_ff, rsp_in;

   logic               mem_rd_en;
   logic               wr_addr_en, wr_seen_en;
   logic [IDX_W-1:0]   wr_idx;
   logic [31:0]        idle_time;
   logic [CNT_W+3:0]   live_ext, evict_ext;

   assign mem_rd_en = (state_ff == S_SCAN) && (rd_cnt_ff < CNT_W'(TABLE_SLOTS));
   assign idle_time = job_ff.now - rd_seen_ff;
   assign q_pop     = (state_ff == S_IDLE) && !q_stat.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_addr_ff <= addr_mem[rd_cnt_ff[IDX_W-1:0]];
         rd_seen_ff <= seen_mem[rd_cnt_ff[IDX_W-1:0]];
      end
      if (wr_addr_en) begin
         addr_mem[wr_idx] <= job_ff.addr;
      end
      if (wr_seen_en) begin
         seen_mem[wr_idx] <= job_ff.now;
      end
   end

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      valid_in      = valid_ff;
      live_in       = live_ff;
      evict_in      = evict_ff;
      rd_cnt_in     = rd_cnt_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = 1'b0;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      match_seen_in = match_seen_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      timeout_in    = csr_we ? csr_wdata : timeout_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      wr_addr_en    = 1'b0;
      wr_seen_en    = 1'b0;
      wr_idx        = free_idx_ff;
      live_ext      = '0;
      evict_ext     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               job_in    = head_job;
               rd_cnt_in = '0;
               match_in  = 1'b0;
               free_in   = 1'b0;
               evict_in  = '0;
               if (head_job.op == cta_pkg::OP_CLEAR || head_job.op == cta_pkg::OP_NOP) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (mem_rd_en) begin
               chk_idx_in = rd_cnt_ff[IDX_W-1:0];
               chk_vld_in = 1'b1;
               rd_cnt_in  = rd_cnt_ff + 1'b1;
            end
            if (chk_vld_ff) begin
               if (!valid_ff[chk_idx_ff] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
               if (valid_ff[chk_idx_ff] && rd_addr_ff == job_ff.addr && !match_ff) begin
                  match_in      = 1'b1;
                  match_idx_in  = chk_idx_ff;
                  match_seen_in = rd_seen_ff;
               end
               if (job_ff.op == cta_pkg::OP_SWEEP && valid_ff[chk_idx_ff]
                   && idle_time > timeout_ff) begin
                  valid_in[chk_idx_ff] = 1'b0;
                  evict_in = evict_ff + 1'b1;
                  live_in  = live_ff - 1'b1;
               end
            end
            if (!mem_rd_en && !chk_vld_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            rsp_valid_in         = 1'b1;
            rsp_in.status        = cta_pkg::STATUS_OK;
            rsp_in.balance       = '0;
            rsp_in.seen_time     = '0;
            rsp_in.evicted_count = '0;
            unique case (job_ff.op)
               cta_pkg::OP_CONNECT: begin
                  if (match_ff) begin
                     rsp_in.status = cta_pkg::STATUS_DUPLICATE;
                  end else if (!free_ff) begin
                     rsp_in.status = cta_pkg::STATUS_FULL;
                  end else begin
                     wr_addr_en            = 1'b1;
                     wr_seen_en            = 1'b1;
                     wr_idx                = free_idx_ff;
                     valid_in[free_idx_ff] = 1'b1;
                     live_in               = live_ff + 1'b1;
                  end
               end
               cta_pkg::OP_DISCONNECT: begin
                  if (match_ff) begin
                     valid_in[match_idx_ff] = 1'b0;
                     live_in                = live_ff - 1'b1;
                  end else begin
                     rsp_in.status = cta_pkg::STATUS_NOT_FOUND;
                  end
               end
               cta_pkg::OP_TOUCH: begin
                  if (match_ff) begin
                     wr_seen_en = 1'b1;
                     wr_idx     = match_idx_ff;
                  end else begin
                     rsp_in.status = cta_pkg::STATUS_NOT_FOUND;
                  end
               end
               cta_pkg::OP_LOOKUP: begin
                  if (match_ff) begin
                     rsp_in.balance   = cta_pkg::START_BALANCE;
                     rsp_in.seen_time = match_seen_ff;
                  end else begin
                     rsp_in.status = cta_pkg::STATUS_NOT_FOUND;
                  end
               end
               cta_pkg::OP_SWEEP: begin
                  evict_ext            = {4'b0, evict_ff};
                  rsp_in.evicted_count = evict_ext[3:0];
               end
               cta_pkg::OP_CLEAR: begin
                  valid_in = '0;
                  live_in  = '0;
               end
               default: begin
               end
            endcase
            live_ext          = {4'b0, live_in};
            rsp_in.live_count = live_ext[3:0];
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         live_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         rd_cnt_ff    <= '0;
         match_ff     <= 1'b0;
         free_ff      <= 1'b0;
         evict_ff     <= '0;
         timeout_ff   <= cta_pkg::TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         live_ff      <= live_in;
         chk_vld_ff   <= chk_vld_in;
         rd_cnt_ff    <= rd_cnt_in;
         match_ff     <= match_in;
         free_ff      <= free_in;
         evict_ff     <= evict_in;
         timeout_ff   <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff        <= job_in;
      chk_idx_ff    <= chk_idx_in;
      match_idx_ff  <= match_idx_in;
      match_seen_ff <= match_seen_in;
      free_idx_ff   <= free_idx_in;
      rsp_ff        <= rsp_in;
   end

endmodule

`default_nettype wire

### hdl/client_table_with_aging_core.sv
`default_nettype none

// Client table with aging. A command is taken at a clock edge with start high and busy low;
// busy stays high for one cycle after each accepted command and longer while the two-entry
// command queue is full. The engine walks every slot of the table memory, one read per
// cycle, for a connect, disconnect, touch, lookup or sweep; a clear or an unused code
// skips the walk and goes straight to its result. One result per
// transaction, in command order, is shown on rsp_data for exactly one cycle with rsp_valid
// high; the receiver cannot stall it and must take it in that cycle. Write csr_wdata
// (timeout in ms, reset 5000) with csr_we only while no command is in flight.
module client_table_with_aging_core #(
   parameter int TABLE_SLOTS = cta_pkg::TABLE_SLOTS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire cta_pkg::req_type  req_data,
   output logic                   rsp_valid,
   output cta_pkg::rsp_type       rsp_data,
   input  wire logic              csr_we,
   input  wire logic [31:0]       csr_wdata
);

   logic                push;
   logic                pop;
   cta_pkg::job_type    push_job;
   cta_pkg::job_type    head_job;
   cta_pkg::q_stat_type q_stat;

   cta_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_stat   (q_stat),
      .q_push   (push),
      .q_job    (push_job)
   );

   cta_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   cta_engine #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .head_job  (head_job),
      .q_stat    (q_stat),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### test/client_table_checker.sv
`default_nettype none

module client_table_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire cta_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire cta_pkg::rsp_type rsp_data,
   input  wire logic             csr_we,
   input  wire logic [31:0]      csr_wdata,
   output int                    errors,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = cta_pkg::TABLE_SLOTS_DEFAULT;

   logic             slot_valid [SLOTS];
   logic [47:0]      slot_addr  [SLOTS];
   logic [31:0]      slot_seen  [SLOTS];
   logic [31:0]      idle_limit;
   cta_pkg::rsp_type expected_rsp_q [$];
   int               fail_count = 0;

   assign errors = fail_count;

   task automatic report(string msg);
      $display("%t ERROR: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic int find_client(logic [47:0] addr);
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_valid[i] && slot_addr[i] == addr) return i;
      end
      return -1;
   endfunction

   function automatic int first_free();
      for (int i = 0; i < SLOTS; i++) begin
         if (!slot_valid[i]) return i;
      end
      return -1;
   endfunction

   // Applies one command to the table copy and returns the response it should give.
   function automatic cta_pkg::rsp_type apply_command(cta_pkg::req_type r);
      cta_pkg::rsp_type res;
      int               hit;
      int               spot;
      int               live;
      int               gone;
      logic [31:0]      age;
      res = '0;
      gone = 0;
      hit = find_client(r.client_addr);
      case (r.cmd)
         cta_pkg::CMD_CONNECT: begin
            if (hit >= 0) begin
               res.status = cta_pkg::STATUS_DUPLICATE;
            end else begin
               spot = first_free();
               if (spot < 0) begin
                  res.status = cta_pkg::STATUS_FULL;
               end else begin
                  slot_valid[spot] = 1'b1;
                  slot_addr[spot]  = r.client_addr;
                  slot_seen[spot]  = r.now_ms;
               end
            end
         end
         cta_pkg::CMD_DISCONNECT: begin
            if (hit < 0) res.status = cta_pkg::STATUS_NOT_FOUND;
            else slot_valid[hit] = 1'b0;
         end
         cta_pkg::CMD_TOUCH: begin
            if (hit < 0) res.status = cta_pkg::STATUS_NOT_FOUND;
            else slot_seen[hit] = r.now_ms;
         end
         cta_pkg::CMD_LOOKUP: begin
            if (hit < 0) begin
               res.status = cta_pkg::STATUS_NOT_FOUND;
            end else begin
               res.balance   = cta_pkg::START_BALANCE;
               res.seen_time = slot_seen[hit];
            end
         end
         cta_pkg::CMD_SWEEP: begin
            for (int i = 0; i < SLOTS; i++) begin
               age = r.now_ms - slot_seen[i];
               if (slot_valid[i] && age > idle_limit) begin
                  slot_valid[i] = 1'b0;
                  gone++;
               end
            end
         end
         cta_pkg::CMD_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
         end
         default: ;
      endcase
      live = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_valid[i]) live++;
      end
      res.live_count    = 4'(live);
      res.evicted_count = 4'(gone);
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      cta_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_addr[i]  = '0;
            slot_seen[i]  = '0;
         end
         idle_limit = cta_pkg::TIMEOUT_RESET;
         expected_rsp_q.delete();
      end else begin
         // response first: it can never belong to a transaction taken at this edge
         if (rsp_valid) begin
            if (expected_rsp_q.size() == 0) begin
               report("response with no transaction outstanding");
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.status !== want.status)
                  report($sformatf("status got %0d expected %0d",
                                   rsp_data.status, want.status));
               if (rsp_data.balance !== want.balance)
                  report($sformatf("balance got %0d expected %0d",
                                   rsp_data.balance, want.balance));
               if (rsp_data.seen_time !== want.seen_time)
                  report($sformatf("seen_time got %0h expected %0h",
                                   rsp_data.seen_time, want.seen_time));
               if (rsp_data.live_count !== want.live_count)
                  report($sformatf("live_count got %0d expected %0d",
                                   rsp_data.live_count, want.live_count));
               if (rsp_data.evicted_count !== want.evicted_count)
                  report($sformatf("evicted_count got %0d expected %0d",
                                   rsp_data.evicted_count, want.evicted_count));
            end
         end
         if (csr_we) idle_limit = csr_wdata;
         if (start && !busy)
            expected_rsp_q.insert(expected_rsp_q.size(), apply_command(req_data));
      end
      pending <= expected_rsp_q.size();
   end

endmodule

`default_nettype wire

### test/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CMD_SPARE_LO   = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI   = 3'd7;
   localparam int         POOL_SIZE      = 10;
   localparam int         PHASES         = 5;
   localparam int         PHASE_ITEMS    = 360;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         DRAIN_CYCLES   = 40;
   localparam logic [47:0] ADDR_ZERO     = 48'h0;
   localparam logic [47:0] ADDR_ONES     = 48'hFFFF_FFFF_FFFF;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             csr_we    = 1'b0;
   logic [31:0]      csr_wdata = '0;
   cta_pkg::req_type req_data  = '0;
   logic             busy;
   logic             rsp_valid;
   cta_pkg::rsp_type rsp_data;
   int               errors;
   int               pending;

   logic [47:0] client_pool [POOL_SIZE];
   logic [31:0] time_cursor = '0;
   int          quiet_cycles = 0;

   client_table_with_aging_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   client_table_checker scoreboard (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .errors    (errors),
      .pending   (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic issue(logic [2:0] cmd, logic [47:0] addr, logic [31:0] now);
      req_data <= '{cmd, addr, now};
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic rest(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_timeout(logic [31:0] value);
      drain();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic cta_pkg::req_type next_command();
      cta_pkg::req_type r;
      int               roll;
      roll = $urandom_range(0, 99);
      r.client_addr = client_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 19) == 0) r.client_addr = 48'({$urandom, $urandom});
      if (roll < 30)      r.cmd = cta_pkg::CMD_CONNECT;
      else if (roll < 42) r.cmd = cta_pkg::CMD_DISCONNECT;
      else if (roll < 57) r.cmd = cta_pkg::CMD_TOUCH;
      else if (roll < 77) r.cmd = cta_pkg::CMD_LOOKUP;
      else if (roll < 91) r.cmd = cta_pkg::CMD_SWEEP;
      else if (roll < 94) r.cmd = cta_pkg::CMD_CLEAR;
      else if (roll < 97) r.cmd = CMD_SPARE_LO;
      else                r.cmd = CMD_SPARE_HI;
      if ($urandom_range(0, 19) == 0) time_cursor = $urandom;
      else time_cursor = time_cursor + $urandom_range(0, 3000);
      r.now_ms = time_cursor;
      return r;
   endfunction

   initial begin
      logic [31:0]      phase_limit [PHASES];
      logic [47:0]      probe;
      cta_pkg::req_type r;
      int               gap_odds;
      int               pause_at;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed pass at the reset timeout
      probe = 48'h5A5A_0000_0100;
      issue(cta_pkg::CMD_LOOKUP, ADDR_ZERO, 32'd0);
      issue(cta_pkg::CMD_CONNECT, ADDR_ZERO, 32'd0);
      issue(cta_pkg::CMD_CONNECT, ADDR_ONES, 32'hFFFF_FFFF);
      issue(cta_pkg::CMD_CONNECT, ADDR_ZERO, 32'd10);
      for (int i = 1; i <= 6; i++) issue(cta_pkg::CMD_CONNECT, probe + 48'(i), 32'd1000);
      issue(cta_pkg::CMD_CONNECT, probe, 32'd1000);
      issue(cta_pkg::CMD_CONNECT, ADDR_ONES, 32'd1000);
      issue(cta_pkg::CMD_LOOKUP, ADDR_ONES, 32'd1000);
      issue(cta_pkg::CMD_TOUCH, ADDR_ZERO, 32'd100);
      issue(cta_pkg::CMD_TOUCH, probe, 32'd100);
      issue(cta_pkg::CMD_DISCONNECT, probe, 32'd100);
      issue(CMD_SPARE_LO, ADDR_ONES, 32'd200);
      issue(CMD_SPARE_HI, ADDR_ZERO, 32'd200);
      // idle exactly at the limit stays, one past it goes
      issue(cta_pkg::CMD_SWEEP, ADDR_ONES, 32'd6000);
      issue(cta_pkg::CMD_SWEEP, ADDR_ZERO, 32'd6001);
      issue(cta_pkg::CMD_CONNECT, ADDR_ZERO, 32'hFFFF_FF00);
      issue(cta_pkg::CMD_SWEEP, ADDR_ZERO, 32'h0000_0100);
      issue(cta_pkg::CMD_LOOKUP, ADDR_ZERO, 32'd300);
      issue(cta_pkg::CMD_DISCONNECT, ADDR_ZERO, 32'd300);
      issue(cta_pkg::CMD_CONNECT, ADDR_ONES, 32'd400);
      issue(cta_pkg::CMD_CLEAR, ADDR_ONES, 32'd400);
      issue(cta_pkg::CMD_LOOKUP, ADDR_ONES, 32'd400);

      phase_limit[0] = 32'd0;
      phase_limit[1] = 32'hFFFF_FFFF;
      phase_limit[2] = $urandom_range(1, 4000);
      phase_limit[3] = cta_pkg::TIMEOUT_RESET;
      phase_limit[4] = $urandom;

      for (int p = 0; p < PHASES; p++) begin
         write_timeout(phase_limit[p]);
         for (int k = 0; k < POOL_SIZE; k++) client_pool[k] = 48'({$urandom, $urandom});
         client_pool[0] = ADDR_ZERO;
         client_pool[1] = ADDR_ONES;
         pause_at = $urandom_range(50, PHASE_ITEMS - 50);
         gap_odds = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) gap_odds = (p == PHASES - 1) ? 0 : $urandom_range(0, 2);
            if (n == pause_at) drain();
            if (gap_odds != 0 && $urandom_range(0, 3) < gap_odds) rest($urandom_range(1, 15));
            r = next_command();
            issue(r.cmd, r.client_addr, r.now_ms);
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
hdl/cta_pkg.sv
hdl/cta_front.sv
hdl/cta_queue.sv
hdl/cta_engine.sv
hdl/client_table_with_aging_core.sv
test/client_table_checker.sv
test/testbench.sv
